// File: design/lvaw_pkg.sv
// Package for the level array access walker.
// Holds store geometry, field layout, codes, state type and the width mask.
// No dependencies.
`default_nettype none
package lvaw_pkg;

  localparam int StoreEntries = 4096;
  localparam int MaxLevels    = 64;
  localparam int AddrW        = $clog2(StoreEntries);
  localparam int PosW         = ((AddrW > 13) ? AddrW : 13) + 1;
  localparam int CntW         = $clog2(MaxLevels);
  localparam int InDataW      = 88;
  localparam int OutDataW     = 32;
  localparam int ValW         = 32;
  localparam int CfgW         = 6;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LEVEL = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIRECT,
    S_CHECK,
    S_DATA,
    S_SWEEP
  } state_e;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            lvl_end;
    logic            arr_end;
  } entry_t;

  function automatic logic [ValW-1:0] width_mask(input logic [CfgW-1:0] vw);
    logic [ValW-1:0] m;
    if (vw >= CfgW'(32)) begin
      m = '1;
    end else begin
      m = ~({ValW{1'b1}} << vw[4:0]);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// File: design/lvaw_store.sv
// Entry store: one write port, one read port, registered read data.
// Depends on lvaw_pkg.
`default_nettype none
module lvaw_store (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [lvaw_pkg::AddrW-1:0] waddr_i,
  input  lvaw_pkg::entry_t          wdata_i,
  input  wire                       re_i,
  input  wire [lvaw_pkg::AddrW-1:0] raddr_i,
  output lvaw_pkg::entry_t          rdata_o
);
  import lvaw_pkg::*;

  entry_t mem [StoreEntries];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: design/level_array_access_walker.sv
// Top level of the level array access walker: stream ports, walk sequencer, output register.
// Depends on lvaw_pkg and lvaw_store.
`default_nettype none
// A load word writes one store entry. A query word walks one array through the single read
// port of the store: each level reads its entry (S_CHECK) and then emits the running sum
// (S_DATA), and every level but the last then sweeps its entries with one read per cycle,
// from the level start up to the element position, or through the next level end when that
// lies at or past it, and then drains the sweep. A position out of range ends the walk
// with a range result. A query with size zero emits its base offset and holds off the input
// until it does. A new word is taken only once the walk is over; results leave through a
// register, so a stalled output only stalls the walk when the next result is ready.
module level_array_access_walker (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [lvaw_pkg::CfgW-1:0]       cfg_wdata_i,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // entry_addr[11:0] entry_value[43:12] entry_level_end[44] entry_array_end[45]
  // base_offset[57:46] struct_size[70:58] array_index[82:71], zeros above
  input  wire [lvaw_pkg::InDataW-1:0]    s_axis_tdata_i,
  // opcode[0]
  input  wire [0:0]                      s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  // value[31:0]
  output logic [lvaw_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                           m_axis_tlast_o,
  // status[1:0]
  output logic [1:0]                     m_axis_tuser_o
);
  import lvaw_pkg::*;

  logic [11:0] in_addr;
  logic [31:0] in_value;
  logic        in_le;
  logic        in_ae;
  logic [11:0] in_base;
  logic [12:0] in_size;
  logic [11:0] in_idx;

  assign in_addr  = s_axis_tdata_i[11:0];
  assign in_value = s_axis_tdata_i[43:12];
  assign in_le    = s_axis_tdata_i[44];
  assign in_ae    = s_axis_tdata_i[45];
  assign in_base  = s_axis_tdata_i[57:46];
  assign in_size  = s_axis_tdata_i[70:58];
  assign in_idx   = s_axis_tdata_i[82:71];

  state_e          state_q, state_d;
  logic [CfgW-1:0] vw_q, vw_d;
  logic [PosW-1:0] limit_q, limit_d;
  logic [PosW-1:0] lstart_q, lstart_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [11:0]     idx_q, idx_d;
  logic [11:0]     cnt_q, cnt_d;
  logic [ValW-1:0] sum_q, sum_d;
  logic [CntW-1:0] n_q, n_d;
  logic            one_q, one_d;
  logic [PosW-1:0] i_q, i_d;
  logic            pend_q, pend_d;
  logic [PosW-1:0] paddr_q, paddr_d;
  logic            fnd_q, fnd_d;
  logic [PosW-1:0] found_q, found_d;
  logic [11:0]     base_q, base_d;

  logic            ov_q, ov_d;
  logic [ValW-1:0] oval_q, oval_d;
  logic            olast_q, olast_d;
  logic [1:0]      ost_q, ost_d;

  logic            accept;
  logic            free;
  logic            we;
  logic [PosW-1:0] waddr_ext;
  entry_t          wdata;
  logic            re;
  logic [PosW-1:0] raddr_ext;
  entry_t          rdata;
  logic            issue;
  logic [ValW-1:0] nsum;
  logic [PosW-1:0] lim_raw;
  logic [11:0]     idx_new;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign free      = !ov_q || m_axis_tready_i;
  assign waddr_ext = PosW'(in_addr);
  assign we        = accept && (s_axis_tuser_i[0] == OP_LOAD) &&
                     (waddr_ext < PosW'(StoreEntries));
  assign wdata     = '{value: in_value, lvl_end: in_le, arr_end: in_ae};
  assign issue     = (i_q < limit_q) && !(fnd_q && (i_q >= pos_q));
  assign nsum      = sum_q + (rdata.value & width_mask(vw_q));
  assign lim_raw   = PosW'(in_base) + PosW'(in_size);
  assign idx_new   = idx_q - cnt_q;

  lvaw_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr_ext[AddrW-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr_ext[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    vw_d     = cfg_we_i ? cfg_wdata_i : vw_q;
    limit_d  = limit_q;
    lstart_d = lstart_q;
    pos_d    = pos_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    n_d      = n_q;
    one_d    = one_q;
    i_d      = i_q;
    pend_d   = pend_q;
    paddr_d  = paddr_q;
    fnd_d    = fnd_q;
    found_d  = found_q;
    base_d   = base_q;
    ov_d     = ov_q && !m_axis_tready_i;
    oval_d   = oval_q;
    olast_d  = olast_q;
    ost_d    = ost_q;
    re       = 1'b0;
    raddr_ext = pos_q;

    case (state_q)
      S_IDLE: begin
        if (accept && (s_axis_tuser_i[0] == OP_QUERY)) begin
          base_d   = in_base;
          limit_d  = (lim_raw > PosW'(StoreEntries)) ? PosW'(StoreEntries) : lim_raw;
          lstart_d = PosW'(in_base);
          pos_d    = PosW'(in_base) + PosW'(in_idx);
          idx_d    = in_idx;
          sum_d    = '0;
          n_d      = '0;
          one_d    = (in_size == 13'd1);
          state_d  = (in_size == 13'd0) ? S_DIRECT : S_CHECK;
        end
      end
      S_DIRECT: begin
        if (free) begin
          ov_d    = 1'b1;
          oval_d  = ValW'(base_q);
          olast_d = 1'b1;
          ost_d   = ST_OK;
          state_d = S_IDLE;
        end
      end
      S_CHECK: begin
        if (pos_q >= limit_q) begin
          if (free) begin
            ov_d    = 1'b1;
            oval_d  = '0;
            olast_d = 1'b1;
            ost_d   = ST_RANGE;
            state_d = S_IDLE;
          end
        end else begin
          re      = 1'b1;
          state_d = S_DATA;
        end
      end
      S_DATA: begin
        if (free) begin
          ov_d   = 1'b1;
          oval_d = nsum;
          sum_d  = nsum;
          n_d    = n_q + 1'b1;
          if (one_q || rdata.arr_end) begin
            olast_d = 1'b1;
            ost_d   = ST_OK;
            state_d = S_IDLE;
          end else if (n_q == CntW'(MaxLevels - 1)) begin
            olast_d = 1'b1;
            ost_d   = ST_LEVEL;
            state_d = S_IDLE;
          end else begin
            olast_d = 1'b0;
            ost_d   = ST_OK;
            i_d     = lstart_q;
            cnt_d   = '0;
            fnd_d   = 1'b0;
            pend_d  = 1'b0;
            state_d = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        raddr_ext = i_q;
        re        = issue;
        pend_d    = issue;
        paddr_d   = i_q;
        if (issue) begin
          i_d = i_q + 1'b1;
        end
        if (pend_q) begin
          if ((paddr_q < pos_q) && rdata.arr_end) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (rdata.lvl_end && !fnd_q) begin
            fnd_d   = 1'b1;
            found_d = paddr_q;
          end
        end else if (!issue) begin
          idx_d = idx_new;
          if (fnd_q) begin
            lstart_d = found_q + 1'b1;
            pos_d    = found_q + 1'b1 + PosW'(idx_new);
          end else begin
            pos_d = limit_q;
          end
          state_d = S_CHECK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vw_q     <= CfgW'(32);
      limit_q  <= '0;
      lstart_q <= '0;
      pos_q    <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
      sum_q    <= '0;
      n_q      <= '0;
      one_q    <= 1'b0;
      i_q      <= '0;
      pend_q   <= 1'b0;
      paddr_q  <= '0;
      fnd_q    <= 1'b0;
      found_q  <= '0;
      base_q   <= '0;
      ov_q     <= 1'b0;
      oval_q   <= '0;
      olast_q  <= 1'b0;
      ost_q    <= ST_OK;
    end else begin
      state_q  <= state_d;
      vw_q     <= vw_d;
      limit_q  <= limit_d;
      lstart_q <= lstart_d;
      pos_q    <= pos_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      n_q      <= n_d;
      one_q    <= one_d;
      i_q      <= i_d;
      pend_q   <= pend_d;
      paddr_q  <= paddr_d;
      fnd_q    <= fnd_d;
      found_q  <= found_d;
      base_q   <= base_d;
      ov_q     <= ov_d;
      oval_q   <= oval_d;
      olast_q  <= olast_d;
      ost_q    <= ost_d;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = oval_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = ost_q;

endmodule
`default_nettype wire

// File: design/lvaw_checker.sv
// Port-level checks for the level array access walker, bound to the top level.
// Depends on lvaw_pkg and level_array_access_walker.
`default_nettype none
module lvaw_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           s_axis_tvalid_i,
  input wire                           s_axis_tready_o,
  input wire [0:0]                     s_axis_tuser_i,
  input wire                           m_axis_tvalid_o,
  input wire                           m_axis_tready_i,
  input wire [lvaw_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input wire                           m_axis_tlast_o,
  input wire [1:0]                     m_axis_tuser_o
);
  import lvaw_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ST_OK) |-> m_axis_tlast_o)
    else $error("non-ok status without last");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_RANGE) |-> (m_axis_tdata_o == '0))
    else $error("range error with nonzero value");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == OP_QUERY)
      |=> !s_axis_tready_o)
    else $error("query did not hold off input");

endmodule

bind level_array_access_walker lvaw_checker u_lvaw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire

// File: verif/level_array_access_walker_test.sv
// Self-checking testbench for level_array_access_walker: builds array structures in the store,
// walks them with queries under random idling on both streams and across value widths.
// Depends on lvaw_pkg and the level_array_access_walker RTL.
module level_array_access_walker_test;
  import lvaw_pkg::*;

  typedef struct {
    logic        op;
    logic [11:0] addr;
    logic [31:0] val;
    logic        le;
    logic        ae;
    logic [11:0] base;
    logic [12:0] size;
    logic [11:0] idx;
    int          nres;
  } word_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    status_e     status;
  } walk_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic [0:0]          in_tuser = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;
  logic [1:0]          out_tuser;

  logic [31:0] mem_val [StoreEntries];
  bit          mem_le [StoreEntries];
  bit          mem_ae [StoreEntries];
  bit          mem_wr [StoreEntries];
  int          cfg_width = 32;

  word_t        pending_words[$];
  walk_result_t planned_sums[$];
  walk_result_t expected_sums[$];
  walk_result_t walk_out[$];
  int           struct_base[$];
  int           struct_size[$];
  int           struct_arrays[$];

  bit quiet = 1'b0;
  int errors = 0;
  int in_gap = 0;
  int out_stall = 0;
  int cur_nres = 0;
  int idle_cycles = 0;
  int n_loads = 0, n_queries = 0, n_results = 0, n_level = 0, n_range = 0;

  level_array_access_walker uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_tdata),
    .s_axis_tuser_i (in_tuser),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_tdata),
    .m_axis_tlast_o (out_tlast),
    .m_axis_tuser_o (out_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Returns 0 when the walk would touch an entry that was never written.
  function automatic bit walk_array(input int b, input int sz, input int ix);
    int lim, lstart, pos, n, cnt, found, rix;
    logic [31:0] sum, mask;
    walk_out.delete();
    if (sz == 0) begin
      walk_out.insert(walk_out.size(), '{32'(b), 1'b1, ST_OK});
      return 1;
    end
    lim = (b + sz > StoreEntries) ? StoreEntries : b + sz;
    mask = (cfg_width >= 32) ? 32'hFFFF_FFFF : (32'd1 << cfg_width) - 32'd1;
    lstart = b;
    pos = b + ix;
    rix = ix;
    sum = '0;
    n = 0;
    forever begin
      if (pos >= lim) begin
        walk_out.insert(walk_out.size(), '{32'd0, 1'b1, ST_RANGE});
        return 1;
      end
      if (!mem_wr[pos]) return 0;
      sum += mem_val[pos] & mask;
      if (sz == 1 || mem_ae[pos]) begin
        walk_out.insert(walk_out.size(), '{sum, 1'b1, ST_OK});
        return 1;
      end
      if (n + 1 >= MaxLevels) begin
        walk_out.insert(walk_out.size(), '{sum, 1'b1, ST_LEVEL});
        return 1;
      end
      walk_out.insert(walk_out.size(), '{sum, 1'b0, ST_OK});
      n++;
      cnt = 0;
      for (int i = lstart; i < pos; i++) begin
        if (!mem_wr[i]) return 0;
        cnt += mem_ae[i];
      end
      rix -= cnt;
      found = lim;
      for (int i = lstart; i < lim; i++) begin
        if (!mem_wr[i]) return 0;
        if (mem_le[i]) begin
          found = i;
          break;
        end
      end
      if (found >= lim) begin
        walk_out.insert(walk_out.size(), '{32'd0, 1'b1, ST_RANGE});
        return 1;
      end
      lstart = found + 1;
      pos = lstart + rix;
    end
  endfunction

  task automatic add_load(input int a, input logic [31:0] v, input bit le, input bit ae);
    word_t w;
    w = '{OP_LOAD, 12'(a), v, le, ae, 12'($urandom), 13'($urandom), 12'($urandom), 0};
    mem_val[a] = v;
    mem_le[a] = le;
    mem_ae[a] = ae;
    mem_wr[a] = 1'b1;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic add_query(input int b, input int sz, input int ix, output bit ok);
    word_t w;
    ok = walk_array(b, sz, ix);
    if (ok) begin
      w = '{OP_QUERY, 12'($urandom), $urandom, 1'($urandom), 1'($urandom),
            12'(b), 13'(sz), 12'(ix), walk_out.size()};
      foreach (walk_out[i]) planned_sums.insert(planned_sums.size(), walk_out[i]);
      pending_words.insert(pending_words.size(), w);
    end
  endtask

  // Lay out arrays level by level: array-end on each array's last element,
  // level-end on the last entry of each level.
  task automatic make_struct(input int b, input int lens[$]);
    int maxlen, sz, off, cnt, k;
    maxlen = 0;
    sz = 0;
    foreach (lens[i]) begin
      sz += lens[i];
      if (lens[i] > maxlen) maxlen = lens[i];
    end
    off = b;
    for (int lv = 0; lv < maxlen; lv++) begin
      cnt = 0;
      foreach (lens[i]) if (lens[i] > lv) cnt++;
      k = 0;
      foreach (lens[i]) begin
        if (lens[i] > lv) begin
          k++;
          add_load(off, $urandom, k == cnt, lv == lens[i] - 1);
          off++;
        end
      end
    end
    struct_base.insert(struct_base.size(), b);
    struct_size.insert(struct_size.size(), sz);
    struct_arrays.insert(struct_arrays.size(), lens.size());
  endtask

  task automatic random_struct();
    int lens[$];
    int sz;
    lens.delete();
    if ($urandom_range(0, 7) == 0) begin
      lens.insert(lens.size(), $urandom_range(60, 70));
    end else begin
      repeat ($urandom_range(1, 6)) lens.insert(lens.size(), $urandom_range(1, 4));
    end
    sz = 0;
    foreach (lens[i]) sz += lens[i];
    make_struct($urandom_range(0, StoreEntries - sz), lens);
  endtask

  task automatic random_query();
    int s, b, sz, na, pick;
    bit ok;
    s = $urandom_range(struct_base.size() > 4 ? struct_base.size() - 4 : 0,
                       struct_base.size() - 1);
    b = struct_base[s];
    sz = struct_size[s];
    na = struct_arrays[s];
    pick = $urandom_range(0, 19);
    ok = 1'b0;
    if (pick < 2) add_query($urandom_range(0, StoreEntries - 1), 0, $urandom, ok);
    else if (pick < 4) add_query(b, 1, $urandom_range(0, 1) ? 0 : $urandom_range(0, 4095), ok);
    else if (pick < 6) add_query(b, $urandom_range(1, sz), $urandom_range(0, na - 1), ok);
    else if (pick < 7) add_query(b, sz, $urandom_range(0, 4095), ok);
    else if (pick < 8) add_query(b, $urandom_range(sz, StoreEntries - b), $urandom_range(0, na), ok);
    if (!ok) add_query(b, sz, $urandom_range(0, na - 1), ok);
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || expected_sums.size() != 0 || in_valid)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_width(input int w);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CfgW'(w);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_width = w;
  endtask

  task automatic random_phase(input int w, input bit q, input int nwords);
    int target;
    drain();
    write_width(w);
    quiet = q;
    target = pending_words.size() + nwords;
    while (pending_words.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1: random_struct();
        2: add_load($urandom_range(0, StoreEntries - 1), $urandom, 1'($urandom), 1'($urandom));
        default: random_query();
      endcase
    end
  endtask

  // Input driver: hold a word until taken, then wait out the drawn gap.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    word_t w;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        repeat (cur_nres) expected_sums.insert(expected_sums.size(), planned_sums.pop_front());
        if (cur_nres == 0) n_loads++;
        else n_queries++;
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap != 0 || pending_words.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap != 0) in_gap <= in_gap - 1;
        end else begin
          w = pending_words.pop_front();
          in_tdata <= {5'b0, w.idx, w.size, w.base, w.ae, w.le, w.val, w.addr};
          in_tuser <= w.op;
          cur_nres <= w.nres;
          in_valid <= 1'b1;
          in_gap <= quiet ? 0 : $urandom_range(0, 15);
        end
      end
    end
  end

  // Result monitor: compare each word with the oldest expectation, stall at random.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    walk_result_t e;
    int stall;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      stall = out_stall;
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_sums.size() == 0) begin
          $error("unexpected result word value=%h last=%b status=%0d",
                 out_tdata, out_tlast, out_tuser);
          errors++;
        end else begin
          e = expected_sums.pop_front();
          if (out_tdata !== e.value) begin
            $error("value: expected %h, got %h", e.value, out_tdata);
            errors++;
          end
          if (out_tlast !== e.last) begin
            $error("last: expected %b, got %b", e.last, out_tlast);
            errors++;
          end
          if (out_tuser !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_tuser);
            errors++;
          end
          if (e.status == ST_LEVEL) n_level++;
          if (e.status == ST_RANGE) n_range++;
        end
        stall = quiet ? 0 : $urandom_range(0, 15);
      end else if (stall != 0) begin
        stall--;
      end
      out_stall <= stall;
      out_ready <= (stall == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_words.size() == 0 && expected_sums.size() == 0 && !in_valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 200000) begin
      $display("** level_array_access_walker: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int lens[$];
    bit ok;
    lens = '{2, 1, 3};
    make_struct(0, lens);
    for (int i = 0; i <= 3; i++) add_query(0, 6, i, ok);
    add_query(0, 4096, 1, ok);
    add_query(0, 4, 2, ok);
    add_query(0, 1, 0, ok);
    add_query(0, 1, 5, ok);
    add_query(4095, 0, 4095, ok);
    add_query(0, 0, 0, ok);
    add_load(4095, 32'hFFFF_FFFF, 1'b1, 1'b1);
    add_load(4094, 32'h0, 1'b0, 1'b0);
    add_query(4095, 1, 0, ok);
    add_query(4095, 4096, 0, ok);
    add_query(4094, 2, 0, ok);
    add_query(0, 6, 4095, ok);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    random_phase(1, 1'b0, 60);
    random_phase(17, 1'b1, 50);
    random_phase(0, 1'b0, 50);
    random_phase(63, 1'b0, 50);
    random_phase(32, 1'b0, 70);
    drain();
    $display("Covered %0d loads and %0d queries over value widths 32, 1, 17, 0, 63, 32;",
             n_loads, n_queries);
    $display("checked %0d result words, %0d level-limit stops, %0d range stops.",
             n_results, n_level, n_range);
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("** level_array_access_walker: PASSED **");
    end else begin
      $display("** level_array_access_walker: FAILED **");
    end
    $finish;
  end

endmodule
